@@ hw/rtl/swmd_pkg.sv @@
// swmd_pkg: shared types and fixed widths for the sliding-window median block.
// No dependencies; imported by swmd_cell and sliding_window_median_deviation.
package swmd_pkg;

    localparam int SAMPLE_W = 32;   // input sample field
    localparam int COST_W   = 39;   // cost result field
    localparam int MEDIAN_W = 32;   // median result field
    localparam int CFG_W    = 7;    // window_size register

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 7'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0]   cost;
        logic [MEDIAN_W-1:0] median;
    } out_item_t;

    // Broadcast control to the sorted cell row; at most one bit is set.
    typedef struct packed {
        logic remove;   // drop one copy of the leaving value, close the gap
        logic insert;   // open a slot and place the new sample
        logic shift;    // move the scan line one cell toward the head
    } cell_ctrl_t;

endpackage

@@ hw/rtl/swmd_ram.sv @@
// swmd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module swmd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/swmd_cell.sv @@
// swmd_cell: one slot of the sorted row plus one slot of the scan line.
// Depends on swmd_pkg (cell_ctrl_t); talks only to its two neighbors.
module swmd_cell #(
    parameter int DATA_BITS = 32
) (
    input  logic                   clk,
    input  swmd_pkg::cell_ctrl_t   ctrl,
    input  logic                   valid,       // slot lies below the fill count
    input  logic [DATA_BITS-1:0]   x,           // sample being inserted
    input  logic [DATA_BITS-1:0]   r,           // sample being removed
    input  logic [DATA_BITS-1:0]   left_value,
    input  logic                   left_gt,
    input  logic [DATA_BITS-1:0]   right_value,
    input  logic [DATA_BITS-1:0]   right_scan,
    output logic [DATA_BITS-1:0]   value,
    output logic                   gt,
    output logic [DATA_BITS-1:0]   scan
);

    import swmd_pkg::*;

    logic [DATA_BITS-1:0] value_reg, value_next;
    logic [DATA_BITS-1:0] scan_reg, scan_next;

    // Empty slots count as larger than anything so the new sample lands at the end.
    assign gt = !valid || (value_reg > x);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.remove && (value_reg >= r))
        begin
            value_next = right_value;
        end
        else if (ctrl.insert && gt)
        begin
            value_next = left_gt ? left_value : x;
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (ctrl.insert)
        begin
            scan_next = value_next;
        end
        else if (ctrl.shift)
        begin
            scan_next = right_scan;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        scan_reg  <= scan_next;
    end

    assign value = value_reg;
    assign scan  = scan_reg;

endmodule

@@ hw/rtl/sliding_window_median_deviation.sv @@
// sliding_window_median_deviation: top level, lower median and absolute-deviation
// cost over a sliding window. Uses swmd_pkg, swmd_ram and swmd_cell.
//
//  channel  | valid        | stall        | payload             | dir
//  ---------+--------------+--------------+---------------------+-----
//  sample   | sample_valid | sample_stall | sample_item (sample, restart) | in
//  result   | result_valid | result_stall | result_item (cost, median)    | out
//  config   | cfg_wr_en    | -            | cfg_wr_data (window_size)     | in
//
// One item at a time. An item that leaves the window short of full runs the
// remove and insert steps; one that fills all k slots (k = effective window size)
// also runs the scan, which shifts the sorted row out one cell per cycle, and then the output step.
// A held result adds cycles only while result_stall stays high.
// Reset is asynchronous, active low: window empty, window_size = 3.
// Writing window_size while idle empties the window; a write in another state
// is lost, and any write holds the sample side off in that cycle. The ring and
// the sorted row need no clearing: only slots below the fill count are ever read.
module sliding_window_median_deviation #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  swmd_pkg::in_item_t               sample_item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output swmd_pkg::out_item_t              result_item,
    input  logic                             cfg_wr_en,
    input  logic [swmd_pkg::CFG_W-1:0]       cfg_wr_data
);

    import swmd_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);   // holds 0..WINDOW_MAX
    localparam int AW    = $clog2(WINDOW_MAX);       // ring address

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REMOVE = 5'b00010,
        S_INSERT = 5'b00100,
        S_SCAN   = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]       window_size_reg, window_size_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [AW-1:0]          wp_reg, wp_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [SAMPLE_BITS-1:0] med_reg, med_next;
    logic [COST_W-1:0]      acc_reg, acc_next;
    logic                   result_valid_reg, result_valid_next;
    out_item_t              result_item_reg, result_item_next;

    logic [CNT_W-1:0]       k;          // effective window size
    logic [CNT_W-1:0]       lc;         // size of the lower half, ceil(k/2)
    logic [CNT_W:0]         k_plus1;
    logic [CNT_W-1:0]       wp_inc;
    logic                   take_in;
    logic                   out_free;

    logic [SAMPLE_BITS-1:0] ring_rd_data;
    logic                   ring_wr_en;

    cell_ctrl_t             cell_ctrl;
    logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] cell_scan  [WINDOW_MAX];
    logic                   cell_gt    [WINDOW_MAX];
    logic                   cell_valid [WINDOW_MAX];
    logic [COST_W-1:0]      scan_head;

    // ------------------------------------------------------------------
    // Effective size: zero reads as one, oversize saturates at WINDOW_MAX.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k = CNT_W'(1);
        end
        else if (32'(window_size_reg) > 32'(WINDOW_MAX))
        begin
            k = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            k = CNT_W'(window_size_reg);
        end
    end

    assign k_plus1 = {1'b0, k} + (CNT_W + 1)'(1);
    assign lc      = k_plus1[CNT_W:1];
    assign wp_inc  = CNT_W'(wp_reg) + CNT_W'(1);

    // ------------------------------------------------------------------
    // Arrival ring. The read port follows the write pointer, so in the cycle
    // after an item is taken it shows the oldest sample (valid once full).
    // ------------------------------------------------------------------
    swmd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (wp_reg),
        .wr_data (x_reg),
        .rd_addr (wp_reg),
        .rd_data (ring_rd_data)
    );

    assign ring_wr_en = (state_reg == S_REMOVE);

    // ------------------------------------------------------------------
    // Sorted row: ascending from cell 0. Remove closes the gap toward the
    // head, insert opens one toward the tail; each is a single state using
    // only neighbor values. Insert also loads the scan line.
    // ------------------------------------------------------------------
    always_comb
    begin
        cell_ctrl        = '0;
        cell_ctrl.remove = (state_reg == S_REMOVE) && (count_reg == k);
        cell_ctrl.insert = (state_reg == S_INSERT);
        cell_ctrl.shift  = (state_reg == S_SCAN);
    end

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] left_value;
        logic                   left_gt;
        logic [SAMPLE_BITS-1:0] right_value;
        logic [SAMPLE_BITS-1:0] right_scan;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_mid_l
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_tail
            assign right_value = cell_value[i];
            assign right_scan  = cell_scan[i];
        end
        else
        begin : g_mid_r
            assign right_value = cell_value[i+1];
            assign right_scan  = cell_scan[i+1];
        end

        assign cell_valid[i] = (CNT_W'(i) < count_reg);

        swmd_cell #(
            .DATA_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .valid       (cell_valid[i]),
            .x           (x_reg),
            .r           (ring_rd_data),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .right_value (right_value),
            .right_scan  (right_scan),
            .value       (cell_value[i]),
            .gt          (cell_gt[i]),
            .scan        (cell_scan[i])
        );
    end

    assign scan_head = COST_W'(cell_scan[0]);

    // ------------------------------------------------------------------
    // Sequencer. Cost = upper_sum - lower_sum + (k odd ? median : 0); the
    // accumulator subtracts the lower half and adds the upper half as the
    // scan line streams past cell 0. Arithmetic wraps at the cost width.
    // ------------------------------------------------------------------
    assign take_in  = sample_valid && (state_reg == S_IDLE);
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next        = state_reg;
        window_size_next  = window_size_reg;
        count_next        = count_reg;
        wp_next           = wp_reg;
        idx_next          = idx_reg;
        x_next            = x_reg;
        med_next          = med_reg;
        acc_next          = acc_reg;
        result_item_next  = result_item_reg;
        result_valid_next = result_valid_reg && result_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_wr_en)
                begin
                    window_size_next = cfg_wr_data;
                    count_next       = '0;
                    wp_next          = '0;
                end
                else if (take_in)
                begin
                    x_next     = SAMPLE_BITS'(sample_item.sample);
                    if (sample_item.restart)
                    begin
                        count_next = '0;
                        wp_next    = '0;
                    end
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                if (count_reg == k)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                count_next = count_reg + CNT_W'(1);
                wp_next    = (wp_inc >= k) ? '0 : AW'(wp_inc);
                if (count_next == k)
                begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                acc_next = (idx_reg < lc) ? (acc_reg - scan_head) : (acc_reg + scan_head);
                if (idx_reg == lc - CNT_W'(1))
                begin
                    med_next = cell_scan[0];
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == k - CNT_W'(1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    result_item_next.cost   = acc_reg + (k[0] ? COST_W'(med_reg) : '0);
                    result_item_next.median = MEDIAN_W'(med_reg);
                    result_valid_next       = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_size_reg  <= WINDOW_SIZE_RST;
            count_reg        <= '0;
            wp_reg           <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_size_reg  <= window_size_next;
            count_reg        <= count_next;
            wp_reg           <= wp_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload: no reset.
    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        med_reg         <= med_next;
        acc_reg         <= acc_next;
        result_item_reg <= result_item_next;
    end

    // Busy while an item is in flight; a window_size write wins over a
    // sample offered in the same cycle, so that sample is held off.
    assign sample_stall = (state_reg != S_IDLE) || cfg_wr_en;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

`ifndef SYNTHESIS
    // Fill count never runs past the window.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= k)
        else $error("fill count above window size");

    // Ring pointer stays inside the window between items.
    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (CNT_W'(wp_reg) < k))
        else $error("write pointer outside window");

    // Scan only runs on a full window and stops at its last cell.
    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((idx_reg < k) && (count_reg == k)))
        else $error("scan outside a full window");

    // A new result only appears after the scan has finished.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output step");
`endif

endmodule
